// ===== design/quadratic_extrapolation_oversampler_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the quadratic extrapolation oversampler
// Shared shorthand for the concurrent checks on the block's ports.
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_EXTRAPOLATION_OVERSAMPLER_DEFINES_SVH
`define QUADRATIC_EXTRAPOLATION_OVERSAMPLER_DEFINES_SVH

// Same-cycle implication, switched off while reset is held.
`define QEO_ASSERT_IMP(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define QEO_ASSERT_NXT(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/qeo_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qeo_pkg
// Types, constants and the microcode table of the quadratic extrapolation
// oversampler.
// ----------------------------------------------------------------------------
package qeo_pkg;

  // Fixed widths of the data path.
  localparam int DATA_W           = 32;
  localparam int FRAC_W           = 16;
  localparam int CHUNK_W          = 16;
  localparam int T_W              = DATA_W + 1;
  localparam int DIFF_W           = DATA_W + 4;
  localparam int SAMPLE_WIDTH_DEF = 32;
  localparam int NUM_CHUNKS_DEF   = 3;
  localparam int CFG_IDX_W        = 1;

  localparam logic [DATA_W-1:0] HALF_INV_PERIOD_SQ_RST = 32'd32768;
  localparam logic [DATA_W-1:0] HALF_INV_PERIOD_RST    = 32'd32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HALF_INV_PERIOD_SQ = 1'b0,
    CFG_HALF_INV_PERIOD    = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    FUNC_SAMPLE = 1'b0,
    FUNC_QUERY  = 1'b1
  } func_t;

  typedef logic [3:0] step_t;

  // Micro-operations of the data path.
  typedef enum logic [2:0] {
    UOP_NOP,
    UOP_LOAD,
    UOP_MAC,
    UOP_SAT,
    UOP_ADD,
    UOP_EMIT_ZERO
  } uop_t;

  typedef enum logic [1:0] {X_D2, X_D1, X_QUAD, X_RES} xsel_t;
  typedef enum logic [1:0] {Y_HIPS, Y_HIP, Y_T} ysel_t;
  typedef enum logic [1:0] {DST_QUAD, DST_LIN, DST_RES, DST_OUT} dst_t;
  typedef enum logic {JC_NEXT, JC_LOOP} jcond_t;

  // One control word of the program.
  typedef struct packed {
    uop_t   uop;
    xsel_t  xsel;
    ysel_t  ysel;
    dst_t   dst;
    logic   wide;
    logic   emit;
    jcond_t cond;
    step_t  target;
    logic   last;
  } uword_t;

  // Control from the sequencer to the data path.
  typedef struct packed {
    logic  act;
    uop_t  uop;
    xsel_t xsel;
    ysel_t ysel;
    dst_t  dst;
    logic  wide;
  } dp_ctrl_t;

  // Status from the data path to the sequencer and the top level.
  typedef struct packed {
    logic cnt_ge2;
    logic cnt_full;
    logic out_free;
  } dp_status_t;

  // Program addresses.
  localparam step_t ST_S_LD_QUAD  = 4'd0;
  localparam step_t ST_S_MAC_QUAD = 4'd1;
  localparam step_t ST_S_SAT_QUAD = 4'd2;
  localparam step_t ST_S_LD_LIN   = 4'd3;
  localparam step_t ST_S_MAC_LIN  = 4'd4;
  localparam step_t ST_S_SAT_LIN  = 4'd5;
  localparam step_t ST_Q_LD_P     = 4'd6;
  localparam step_t ST_Q_MAC_P    = 4'd7;
  localparam step_t ST_Q_SAT_P    = 4'd8;
  localparam step_t ST_Q_ADD_LIN  = 4'd9;
  localparam step_t ST_Q_LD_R     = 4'd10;
  localparam step_t ST_Q_MAC_R    = 4'd11;
  localparam step_t ST_Q_SAT_R    = 4'd12;
  localparam step_t ST_Q_ADD_C    = 4'd13;
  localparam step_t ST_Q_INVALID  = 4'd14;

  localparam step_t ENTRY_SAMPLE  = ST_S_LD_QUAD;
  localparam step_t ENTRY_QUERY   = ST_Q_LD_P;
  localparam step_t ENTRY_NOVALID = ST_Q_INVALID;

  function automatic uword_t mk_uw(uop_t u, xsel_t x, ysel_t y, dst_t d, logic wide,
                                   logic emit, jcond_t c, step_t tgt, logic last);
    uword_t w;
    w.uop    = u;
    w.xsel   = x;
    w.ysel   = y;
    w.dst    = d;
    w.wide   = wide;
    w.emit   = emit;
    w.cond   = c;
    w.target = tgt;
    w.last   = last;
    return w;
  endfunction

  // The program: coefficient update for samples, evaluation or a zero result for queries.
  function automatic uword_t ucode_rom(step_t pc);
    uword_t w;
    unique case (pc)
      ST_S_LD_QUAD:  w = mk_uw(UOP_LOAD, X_D2, Y_HIPS, DST_RES, 1'b1, 1'b0, JC_NEXT,
                               ST_S_LD_QUAD, 1'b0);
      ST_S_MAC_QUAD: w = mk_uw(UOP_MAC, X_D2, Y_HIPS, DST_RES, 1'b1, 1'b0, JC_LOOP,
                               ST_S_MAC_QUAD, 1'b0);
      ST_S_SAT_QUAD: w = mk_uw(UOP_SAT, X_D2, Y_HIPS, DST_QUAD, 1'b1, 1'b0, JC_NEXT,
                               ST_S_SAT_QUAD, 1'b0);
      ST_S_LD_LIN:   w = mk_uw(UOP_LOAD, X_D1, Y_HIP, DST_RES, 1'b1, 1'b0, JC_NEXT,
                               ST_S_LD_LIN, 1'b0);
      ST_S_MAC_LIN:  w = mk_uw(UOP_MAC, X_D1, Y_HIP, DST_RES, 1'b1, 1'b0, JC_LOOP,
                               ST_S_MAC_LIN, 1'b0);
      ST_S_SAT_LIN:  w = mk_uw(UOP_SAT, X_D1, Y_HIP, DST_LIN, 1'b1, 1'b0, JC_NEXT,
                               ST_S_SAT_LIN, 1'b1);
      ST_Q_LD_P:     w = mk_uw(UOP_LOAD, X_QUAD, Y_T, DST_RES, 1'b1, 1'b0, JC_NEXT,
                               ST_Q_LD_P, 1'b0);
      ST_Q_MAC_P:    w = mk_uw(UOP_MAC, X_QUAD, Y_T, DST_RES, 1'b1, 1'b0, JC_LOOP,
                               ST_Q_MAC_P, 1'b0);
      ST_Q_SAT_P:    w = mk_uw(UOP_SAT, X_QUAD, Y_T, DST_RES, 1'b1, 1'b0, JC_NEXT,
                               ST_Q_SAT_P, 1'b0);
      ST_Q_ADD_LIN:  w = mk_uw(UOP_ADD, X_RES, Y_T, DST_RES, 1'b1, 1'b0, JC_NEXT,
                               ST_Q_ADD_LIN, 1'b0);
      ST_Q_LD_R:     w = mk_uw(UOP_LOAD, X_RES, Y_T, DST_RES, 1'b0, 1'b0, JC_NEXT,
                               ST_Q_LD_R, 1'b0);
      ST_Q_MAC_R:    w = mk_uw(UOP_MAC, X_RES, Y_T, DST_RES, 1'b0, 1'b0, JC_LOOP,
                               ST_Q_MAC_R, 1'b0);
      ST_Q_SAT_R:    w = mk_uw(UOP_SAT, X_RES, Y_T, DST_RES, 1'b0, 1'b0, JC_NEXT,
                               ST_Q_SAT_R, 1'b0);
      ST_Q_ADD_C:    w = mk_uw(UOP_ADD, X_RES, Y_T, DST_OUT, 1'b0, 1'b1, JC_NEXT,
                               ST_Q_ADD_C, 1'b1);
      ST_Q_INVALID:  w = mk_uw(UOP_EMIT_ZERO, X_RES, Y_T, DST_OUT, 1'b0, 1'b1, JC_NEXT,
                               ST_Q_INVALID, 1'b1);
      default:       w = mk_uw(UOP_NOP, X_RES, Y_T, DST_RES, 1'b0, 1'b0, JC_NEXT,
                               ST_S_LD_QUAD, 1'b1);
    endcase
    return w;
  endfunction

endpackage

// ===== design/qeo_interfaces.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qeo_in_if / qeo_out_if
// Valid/ready channels for input items and for results.
// ----------------------------------------------------------------------------

// Input channel: a new sample or a query.
interface qeo_in_if;
  logic                     valid;
  logic                     ready;
  logic                     func;
  logic signed [31:0]       stamp;
  logic signed [31:0]       sample_value;

  modport source (output valid, output func, output stamp, output sample_value,
                  input ready);
  modport sink   (input valid, input func, input stamp, input sample_value,
                  output ready);
endinterface

// Result channel: one estimate per query.
interface qeo_out_if;
  logic                     valid;
  logic                     ready;
  logic signed [31:0]       estimate;
  logic                     estimate_valid;

  modport source (output valid, output estimate, output estimate_valid, input ready);
  modport sink   (input valid, input estimate, input estimate_valid, output ready);
endinterface

// ===== design/qeo_useq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qeo_useq
// Microcode sequencer: step counter, loop counter and program table.
// ----------------------------------------------------------------------------
module qeo_useq #(
  parameter int NUM_CHUNKS = qeo_pkg::NUM_CHUNKS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  qeo_pkg::step_t        entry,
  input  qeo_pkg::dp_status_t   status,
  output qeo_pkg::dp_ctrl_t     ctrl,
  output logic                  busy
);

  localparam int CNT_W = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;

  logic                 busy_r, busy_nxt;
  qeo_pkg::step_t       pc_r, pc_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  qeo_pkg::uword_t      uw;
  logic                 fire;

  // Step and loop registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= qeo_pkg::ENTRY_SAMPLE;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Fetch, stall on a full result register, and branch.
  always_comb begin
    uw       = qeo_pkg::ucode_rom(pc_r);
    fire     = busy_r && !(uw.emit && !status.out_free);
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    cnt_nxt  = cnt_r;
    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        pc_nxt   = entry;
      end
    end else if (fire) begin
      if (uw.uop == qeo_pkg::UOP_LOAD) begin
        cnt_nxt = CNT_W'(NUM_CHUNKS - 1);
      end else if (uw.uop == qeo_pkg::UOP_MAC && cnt_r != '0) begin
        cnt_nxt = cnt_r - 1'b1;
      end
      if (uw.cond == qeo_pkg::JC_LOOP && cnt_r != '0) begin
        pc_nxt = uw.target;
      end else if (uw.last) begin
        busy_nxt = 1'b0;
      end else begin
        pc_nxt = pc_r + qeo_pkg::step_t'(1);
      end
    end
  end

  assign ctrl.act  = fire;
  assign ctrl.uop  = uw.uop;
  assign ctrl.xsel = uw.xsel;
  assign ctrl.ysel = uw.ysel;
  assign ctrl.dst  = uw.dst;
  assign ctrl.wide = uw.wide;
  assign busy      = busy_r;

endmodule

// ===== design/qeo_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qeo_datapath
// Sample history, coefficients, a shared 16-bit slice multiplier with
// accumulator, saturation and the result register.
// ----------------------------------------------------------------------------
module qeo_datapath #(
  parameter int SAMPLE_WIDTH = qeo_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_accept,
  input  logic                                in_func,
  input  logic signed [qeo_pkg::DATA_W-1:0]   in_stamp,
  input  logic signed [qeo_pkg::DATA_W-1:0]   in_sample,
  input  logic                                cfg_we,
  input  logic [qeo_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [qeo_pkg::DATA_W-1:0]          cfg_wdata,
  input  qeo_pkg::dp_ctrl_t                   ctrl,
  output qeo_pkg::dp_status_t                 status,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic signed [qeo_pkg::DATA_W-1:0]   estimate,
  output logic                                estimate_valid
);

  localparam int DW     = qeo_pkg::DATA_W;
  localparam int FW     = qeo_pkg::FRAC_W;
  localparam int CW     = qeo_pkg::CHUNK_W;
  localparam int TW     = qeo_pkg::T_W;
  localparam int DFW    = qeo_pkg::DIFF_W;
  localparam int COEF_W = SAMPLE_WIDTH + FW;
  localparam int OPW    = (COEF_W > DFW) ? COEF_W : DFW;
  localparam int NCH    = (OPW + CW - 1) / CW;
  localparam int XPW    = NCH * CW;
  localparam int AW     = XPW + TW;
  localparam int MW     = AW - FW;
  localparam int SW     = COEF_W + 1;

  localparam logic [MW-1:0] COEF_MAX_M = {{(MW - COEF_W + 1){1'b0}}, {(COEF_W - 1){1'b1}}};
  localparam logic [MW-1:0] W32_MAX_M  = {{(MW - DW + 1){1'b0}}, {(DW - 1){1'b1}}};
  localparam logic signed [SW-1:0] COEF_HI_S = {2'b00, {(COEF_W - 1){1'b1}}};
  localparam logic signed [SW-1:0] W32_HI_S  = {{(SW - DW + 1){1'b0}}, {(DW - 1){1'b1}}};

  // Control state.
  logic [DW-1:0]               hips_r, hip_r;
  logic [1:0]                  count_r;
  logic                        out_valid_r;

  // Payload state.
  logic signed [DW-1:0]        older_r, middle_r, const_r, newest_r;
  logic signed [COEF_W-1:0]    quad_r, lin_r, res_r;
  logic signed [DFW-1:0]       d2_r, d1_r;
  logic signed [TW-1:0]        t_r;
  logic [XPW-1:0]              mx_r;
  logic [TW-1:0]               my_r;
  logic                        neg_r;
  logic [AW-1:0]               acc_r;
  logic signed [DW-1:0]        estimate_r;
  logic                        est_valid_r;

  logic signed [DFW-1:0]       s0, s1, s2, d2_new, d1_new;
  logic signed [TW-1:0]        t_new;
  logic signed [OPW-1:0]       x_ext;
  logic [OPW-1:0]              x_mag;
  logic [TW-1:0]               y_mag;
  logic                        y_sgn;
  logic [CW-1:0]               chunk;
  logic [CW+TW-1:0]            prod;
  logic [AW-1:0]               acc_mac;
  logic [MW-1:0]               m, lim, m_sat;
  logic [COEF_W-1:0]           mag_c, sat_val;
  logic signed [SW-1:0]        addend, sum, hi, lo, sum_sat;
  logic                        emit;

  // Second difference and slope term of the three newest samples, and the query time offset.
  always_comb begin
    s0     = DFW'(older_r);
    s1     = DFW'(middle_r);
    s2     = DFW'(in_sample);
    d2_new = s0 - (s1 <<< 1) + s2;
    d1_new = s0 - (s1 <<< 2) + (s2 <<< 1) + s2;
    t_new  = TW'(in_stamp) - TW'(newest_r);
  end

  // Operand selection and sign split for the magnitude multiplier.
  always_comb begin
    unique case (ctrl.xsel)
      qeo_pkg::X_D2:   x_ext = OPW'(d2_r);
      qeo_pkg::X_D1:   x_ext = OPW'(d1_r);
      qeo_pkg::X_QUAD: x_ext = OPW'(quad_r);
      qeo_pkg::X_RES:  x_ext = OPW'(res_r);
      default:         x_ext = '0;
    endcase
    x_mag = x_ext[OPW-1] ? (~x_ext + 1'b1) : x_ext;
    unique case (ctrl.ysel)
      qeo_pkg::Y_HIPS: begin
        y_sgn = 1'b0;
        y_mag = TW'(hips_r);
      end
      qeo_pkg::Y_HIP: begin
        y_sgn = 1'b0;
        y_mag = TW'(hip_r);
      end
      qeo_pkg::Y_T: begin
        y_sgn = t_r[TW-1];
        y_mag = t_r[TW-1] ? (~t_r + 1'b1) : t_r;
      end
      default: begin
        y_sgn = 1'b0;
        y_mag = '0;
      end
    endcase
  end

  // One 16-bit slice of the multiplicand per step, most significant first.
  always_comb begin
    chunk   = mx_r[XPW-1 -: CW];
    prod    = chunk * my_r;
    acc_mac = (acc_r << CW) + AW'(prod);
  end

  // Drop the fraction bits, clamp the magnitude and restore the sign.
  always_comb begin
    m       = acc_r[AW-1:FW];
    lim     = (ctrl.wide ? COEF_MAX_M : W32_MAX_M) + MW'(neg_r);
    m_sat   = (m > lim) ? lim : m;
    mag_c   = m_sat[COEF_W-1:0];
    sat_val = neg_r ? (~mag_c + 1'b1) : mag_c;
  end

  // Saturating add of the linear coefficient or the constant term.
  always_comb begin
    addend = ctrl.wide ? SW'(lin_r) : SW'(const_r);
    sum    = SW'(res_r) + addend;
    hi     = ctrl.wide ? COEF_HI_S : W32_HI_S;
    lo     = ~hi;
    if (sum > hi) begin
      sum_sat = hi;
    end else if (sum < lo) begin
      sum_sat = lo;
    end else begin
      sum_sat = sum;
    end
  end

  assign emit = ctrl.act &&
                ((ctrl.uop == qeo_pkg::UOP_ADD && ctrl.dst == qeo_pkg::DST_OUT) ||
                 ctrl.uop == qeo_pkg::UOP_EMIT_ZERO);

  // Registers, sample count and result handshake.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hips_r      <= qeo_pkg::HALF_INV_PERIOD_SQ_RST;
      hip_r       <= qeo_pkg::HALF_INV_PERIOD_RST;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (qeo_pkg::cfg_reg_t'(cfg_index))
          qeo_pkg::CFG_HALF_INV_PERIOD_SQ: hips_r <= cfg_wdata;
          qeo_pkg::CFG_HALF_INV_PERIOD:    hip_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_accept && in_func == qeo_pkg::FUNC_SAMPLE && count_r != 2'd3) begin
        count_r <= count_r + 2'd1;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Sample history and the arithmetic steps.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      if (in_func == qeo_pkg::FUNC_SAMPLE) begin
        if (count_r[1]) begin
          d2_r    <= d2_new;
          d1_r    <= d1_new;
          const_r <= in_sample;
        end
        older_r  <= middle_r;
        middle_r <= in_sample;
        newest_r <= in_stamp;
      end else begin
        t_r <= t_new;
      end
    end
    if (ctrl.act) begin
      unique case (ctrl.uop)
        qeo_pkg::UOP_LOAD: begin
          mx_r  <= XPW'(x_mag);
          my_r  <= y_mag;
          neg_r <= x_ext[OPW-1] ^ y_sgn;
          acc_r <= '0;
        end
        qeo_pkg::UOP_MAC: begin
          acc_r <= acc_mac;
          mx_r  <= mx_r << CW;
        end
        qeo_pkg::UOP_SAT: begin
          unique case (ctrl.dst)
            qeo_pkg::DST_QUAD: quad_r <= sat_val;
            qeo_pkg::DST_LIN:  lin_r  <= sat_val;
            default:           res_r  <= sat_val;
          endcase
        end
        qeo_pkg::UOP_ADD: begin
          if (ctrl.dst == qeo_pkg::DST_OUT) begin
            estimate_r  <= sum_sat[DW-1:0];
            est_valid_r <= 1'b1;
          end else begin
            res_r <= sum_sat[COEF_W-1:0];
          end
        end
        qeo_pkg::UOP_EMIT_ZERO: begin
          estimate_r  <= '0;
          est_valid_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign status.cnt_ge2  = count_r[1];
  assign status.cnt_full = &count_r;
  assign status.out_free = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign estimate        = estimate_r;
  assign estimate_valid  = est_valid_r;

endmodule

// ===== design/quadratic_extrapolation_oversampler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_extrapolation_oversampler
// Fits a parabola through the three newest samples and evaluates it at
// query times, in signed Q16.16 with saturation.
// ----------------------------------------------------------------------------
// Usage:
// in_ch carries transactions with func = 0 (a new sample at time stamp) or
// func = 1 (a query at time stamp). Each query yields one transaction on
// out_ch; samples yield none. Until three samples are held, a query returns
// estimate 0 with estimate_valid low.
// The two period reciprocals are written through cfg_we/cfg_index/cfg_wdata,
// by the user only while the block is idle; the block does not enforce it.
// The first two samples are only stored and leave in_ch.ready high. A later
// sample rebuilds both coefficients and keeps in_ch.ready low until the
// update is done. A query keeps in_ch.ready low until its estimate reaches
// the result register; an early query only writes the zero estimate there.
// Every product goes through the single shared 16 x 33 multiplier one 16-bit
// slice at a time, three slices by default.
// Reset clears the sample count and the result valid flag and loads both
// reciprocals with 0.5. If out_ch stalls, the finished result waits in its
// register; a following sample is still processed, and a following query
// waits at its final step until the register is free.
// ----------------------------------------------------------------------------
module quadratic_extrapolation_oversampler #(
  parameter int SAMPLE_WIDTH = qeo_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  qeo_in_if.sink                            in_ch,
  qeo_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [qeo_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [qeo_pkg::DATA_W-1:0]        cfg_wdata
);

  localparam int COEF_W = SAMPLE_WIDTH + qeo_pkg::FRAC_W;
  localparam int OPW    = (COEF_W > qeo_pkg::DIFF_W) ? COEF_W : qeo_pkg::DIFF_W;
  localparam int NCH    = (OPW + qeo_pkg::CHUNK_W - 1) / qeo_pkg::CHUNK_W;

  logic                   busy;
  logic                   in_accept;
  logic                   start;
  qeo_pkg::step_t         entry;
  qeo_pkg::dp_ctrl_t      ctrl;
  qeo_pkg::dp_status_t    status;

  // Input handshake and choice of program entry.
  assign in_ch.ready = !busy;
  assign in_accept   = in_ch.valid && !busy;
  assign start       = in_accept && (in_ch.func == qeo_pkg::FUNC_QUERY || status.cnt_ge2);
  assign entry       = (in_ch.func == qeo_pkg::FUNC_QUERY) ?
                       (status.cnt_full ? qeo_pkg::ENTRY_QUERY : qeo_pkg::ENTRY_NOVALID) :
                       qeo_pkg::ENTRY_SAMPLE;

  qeo_useq #(
    .NUM_CHUNKS (NCH)
  ) u_useq (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .entry  (entry),
    .status (status),
    .ctrl   (ctrl),
    .busy   (busy)
  );

  qeo_datapath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_accept      (in_accept),
    .in_func        (in_ch.func),
    .in_stamp       (in_ch.stamp),
    .in_sample      (in_ch.sample_value),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .ctrl           (ctrl),
    .status         (status),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .estimate       (out_ch.estimate),
    .estimate_valid (out_ch.estimate_valid)
  );

endmodule

// ===== design/qeo_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qeo_checker
// Port-level checks of the oversampler, bound to the top level.
// ----------------------------------------------------------------------------
`include "quadratic_extrapolation_oversampler_defines.svh"

module qeo_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           in_func,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [qeo_pkg::DATA_W-1:0]     out_estimate,
  input logic                           out_estimate_valid
);

  // A stalled result stays offered.
  `QEO_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // A stalled result keeps its payload.
  `QEO_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_estimate) && $stable(out_estimate_valid), "result changed while stalled")

  // An invalid estimate always reads as zero.
  `QEO_ASSERT_IMP(a_invalid_zero, clk, rst_n, out_valid && !out_estimate_valid, out_estimate == '0, "invalid estimate is not zero")

  // A query occupies the block for at least the following cycle.
  `QEO_ASSERT_NXT(a_query_busy, clk, rst_n, in_valid && in_ready && in_func, !in_ready, "ready straight after a query transaction")

endmodule

bind quadratic_extrapolation_oversampler qeo_checker u_qeo_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .in_func            (in_ch.func),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_estimate       (out_ch.estimate),
  .out_estimate_valid (out_ch.estimate_valid)
);
